/* rtl/tmeu_pkg.sv */
// Shared types and constants of the tape machine execute unit.
package tmeu_pkg;

    localparam int WORD_W = 16;
    localparam int ARG_W  = 13;
    localparam int OP_W   = 3;
    localparam int PC_W   = 13;
    localparam int PTR_W  = 16;
    localparam int BYTE_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_EMIT  = 3'd4,
        OP_STAMP = 3'd5,
        OP_JZ    = 3'd6,
        OP_JNZ   = 3'd7
    } t_op;

    typedef struct packed {
        logic [WORD_W-1:0] instruction_word;
    } t_in;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              halted;
    } t_out;

    // One classified instruction as it waits in the queue.
    typedef struct packed {
        logic             is_halt;
        t_op              op;
        logic [ARG_W-1:0] arg;
    } t_item;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_q_head;

endpackage

/* rtl/tmeu_stream_if.sv */
// Valid/ready stream interface used by the input and result channels.
interface tmeu_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tape_machine_execute_unit_core.sv */
// Top level of the tape machine execute unit: front end, queue and back end.
//
// Input channel i_instr carries one 16-bit instruction word per beat; the
// result channel o_result returns exactly one beat per instruction with the
// next program counter, the emitted byte and its flag, and the halt flag.
// A beat accepted into an empty queue is executed from the queue head once the
// result register is free, and its result beat is registered. Throughput is
// one instruction per cycle for every opcode, pointer moves included, unless
// the receiver stalls: the back end keeps the byte at the pointer in a register
// and fetches the byte at a new pointer through the store's registered read
// port in the cycle of the move. After reset the data store is cleared by a
// sweep of all DATA_DEPTH addresses, one byte a cycle through the store's
// single write port; i_instr.ready stays low until it ends. DATA_DEPTH and
// PROGRAM_DEPTH must be powers of two. When the receiver stalls, the result
// register holds its beat, the back end stops, the two-entry queue fills and
// then i_instr.ready drops. After the halt word every further beat is accepted
// and answered with the halted program counter, no byte and the halt flag set.
module tape_machine_execute_unit_core #(
    parameter int DATA_DEPTH    = 65536,
    parameter int PROGRAM_DEPTH = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmeu_stream_if.sink   i_instr,
    tmeu_stream_if.source o_result
);

    tmeu_pkg::t_q_head head;
    logic              pop;
    logic              clr_busy;

    tmeu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (i_instr),
        .i_hold  (clr_busy),
        .i_pop   (pop),
        .o_head  (head)
    );

    tmeu_back #(
        .DATA_DEPTH    (DATA_DEPTH),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_clr_busy (clr_busy),
        .o_result   (o_result)
    );

endmodule

/* rtl/tmeu_front.sv */
// Front end: accepts instruction beats, decodes them and queues them for the back end.
module tmeu_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tmeu_stream_if.sink          i_instr,
    input  logic                 i_hold,
    input  logic                 i_pop,
    output tmeu_pkg::t_q_head    o_head
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    tmeu_pkg::t_item            r_q [QDEPTH];
    logic [QAW-1:0]             r_wp;
    logic [QAW-1:0]             r_rp;
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           n_cnt;
    logic                       push;
    tmeu_pkg::t_item            dec;

    assign i_instr.ready = (r_cnt != CNT_W'(QDEPTH)) && !i_hold;
    assign push          = i_instr.valid && i_instr.ready;

    always_comb begin
        dec.is_halt = (i_instr.data.instruction_word == '0);
        dec.op      = tmeu_pkg::t_op'(i_instr.data.instruction_word[
                          tmeu_pkg::WORD_W-1 -: tmeu_pkg::OP_W]);
        dec.arg     = i_instr.data.instruction_word[tmeu_pkg::ARG_W-1:0];
    end

    always_comb begin
        case ({push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    assign o_head.vld  = (r_cnt != '0);
    assign o_head.item = r_q[r_rp];

endmodule

/* rtl/tmeu_back.sv */
// Back end: executes queued instructions against the data store and drives the result channel.
module tmeu_back #(
    parameter int DATA_DEPTH    = 65536,
    parameter int PROGRAM_DEPTH = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmeu_pkg::t_q_head    i_head,
    output logic                 o_pop,
    output logic                 o_clr_busy,
    tmeu_stream_if.source        o_result
);

    localparam int AW = $clog2(DATA_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);

    logic [tmeu_pkg::BYTE_W-1:0]  mem [DATA_DEPTH];

    logic [tmeu_pkg::PTR_W-1:0]   r_ptr,  n_ptr;
    logic [PW-1:0]                r_pc,   n_pc;
    logic [tmeu_pkg::BYTE_W-1:0]  r_cnt,  n_cnt;
    logic                         r_halt, n_halt;
    logic [tmeu_pkg::BYTE_W-1:0]  r_cell, n_cell;
    logic                         r_rd_pend, n_rd_pend;
    logic [tmeu_pkg::BYTE_W-1:0]  r_rd_data;
    logic                         r_clr_busy;
    logic [AW-1:0]                r_clr_addr;
    logic                         r_out_vld, n_out_vld;
    tmeu_pkg::t_out               r_out, n_out;

    logic                         exec;
    logic [tmeu_pkg::BYTE_W-1:0]  cell_cur;
    logic                         wr_en;
    logic [tmeu_pkg::BYTE_W-1:0]  wr_data;
    logic [tmeu_pkg::ARG_W-1:0]   target;
    logic [tmeu_pkg::ARG_W-1:0]   target_inc;
    logic                         moved;
    logic                         emit;
    tmeu_pkg::t_item              it;

    // The byte at the pointer lives in r_cell; right after a pointer move it
    // comes from the registered memory read instead.
    assign cell_cur = r_rd_pend ? r_rd_data : r_cell;
    assign exec     = i_head.vld && !r_clr_busy && (!r_out_vld || o_result.ready);
    assign o_pop    = exec;
    assign it       = i_head.item;

    always_comb begin
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_halt     = r_halt;
        wr_en      = 1'b0;
        wr_data    = cell_cur;
        moved      = 1'b0;
        emit       = 1'b0;
        target     = tmeu_pkg::ARG_W'(r_pc);
        target_inc = target + tmeu_pkg::ARG_W'(1);
        n_pc       = r_pc;
        if (exec && !r_halt) begin
            if (it.is_halt) begin
                n_halt = 1'b1;
            end else begin
                unique case (it.op)
                    tmeu_pkg::OP_ADD: begin
                        wr_en   = 1'b1;
                        wr_data = cell_cur + it.arg[tmeu_pkg::BYTE_W-1:0];
                    end
                    tmeu_pkg::OP_SUB: begin
                        wr_en   = 1'b1;
                        wr_data = cell_cur - it.arg[tmeu_pkg::BYTE_W-1:0];
                    end
                    tmeu_pkg::OP_RIGHT: begin
                        moved = 1'b1;
                        n_ptr = r_ptr + tmeu_pkg::PTR_W'(it.arg);
                    end
                    tmeu_pkg::OP_LEFT: begin
                        moved = 1'b1;
                        n_ptr = r_ptr - tmeu_pkg::PTR_W'(it.arg);
                    end
                    tmeu_pkg::OP_EMIT: begin
                        emit = 1'b1;
                    end
                    tmeu_pkg::OP_STAMP: begin
                        wr_en   = 1'b1;
                        wr_data = r_cnt;
                    end
                    tmeu_pkg::OP_JZ: begin
                        if (cell_cur == '0) begin
                            target = it.arg;
                        end
                    end
                    tmeu_pkg::OP_JNZ: begin
                        if (cell_cur != '0) begin
                            target = it.arg;
                        end
                    end
                endcase
                target_inc = target + tmeu_pkg::ARG_W'(1);
                n_pc       = target_inc[PW-1:0];
                n_cnt      = r_cnt + tmeu_pkg::BYTE_W'(1);
            end
        end
        n_cell    = wr_en ? wr_data : cell_cur;
        n_rd_pend = moved;
    end

    always_comb begin
        n_out.next_pc   = tmeu_pkg::PC_W'(n_pc);
        n_out.out_valid = emit;
        n_out.out_byte  = emit ? cell_cur : '0;
        n_out.halted    = n_halt;
        if (exec) begin
            n_out_vld = 1'b1;
        end else if (o_result.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_pc       <= '0;
            r_cnt      <= '0;
            r_halt     <= 1'b0;
            r_cell     <= '0;
            r_rd_pend  <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_pc      <= n_pc;
            r_cnt     <= n_cnt;
            r_halt    <= n_halt;
            r_cell    <= n_cell;
            r_rd_pend <= n_rd_pend;
            r_out_vld <= n_out_vld;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DATA_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= n_out;
        end
    end

    // Single write port shared by the clearing sweep and the execute path;
    // the read port fetches the byte at the next pointer every cycle.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            mem[r_ptr[AW-1:0]] <= wr_data;
        end
        r_rd_data <= mem[n_ptr[AW-1:0]];
    end

    assign o_clr_busy     = r_clr_busy;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

/* rtl/tmeu_checker.sv */
// Port-level checks of the result channel, bound to the top level.
module tmeu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input tmeu_pkg::t_out i_out_data
);

    logic                      r_seen_halt;
    logic [tmeu_pkg::PC_W-1:0] r_halt_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
            r_halt_pc   <= '0;
        end else if (i_out_valid && i_out_ready && i_out_data.halted && !r_seen_halt) begin
            r_seen_halt <= 1'b1;
            r_halt_pc   <= i_out_data.next_pc;
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    a_no_emit_when_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.out_valid && i_out_data.halted))
        else $error("byte emitted on a halted result");

    a_quiet_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.out_valid |-> i_out_data.out_byte == '0)
        else $error("nonzero byte without emit flag");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_halt |-> i_out_data.halted && i_out_data.next_pc == r_halt_pc)
        else $error("state changed after halt");

endmodule

bind tape_machine_execute_unit_core tmeu_checker u_tmeu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
